>>> hw/rtl/lmf_pkg.sv
// Shared types and constants for the LED matrix frame buffer.
package lmf_pkg;

	// Field widths
	localparam int MODE_W  = 3;
	localparam int CH_W    = 8;
	localparam int RGB_W   = 3 * CH_W;
	localparam int COORD_W = 4;
	localparam int ADDR_W  = 8;

	// Command modes as they arrive on the input channel
	localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FILL_ALL  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RECT      = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REFRESH   = 3'd5;

	// Operations handed to the back end
	localparam logic OP_DRAW    = 1'b0;
	localparam logic OP_REFRESH = 1'b1;

	// Command queue sizing
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Normalized command: a clipped rectangle to paint, or a row to scan out
	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [RGB_W-1:0]   rgb;
	} cmd_t;

endpackage

>>> hw/rtl/lmf_front.sv
// Front end: accepts command words, clips and classifies them, drops no-ops.
module lmf_front #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lmf_pkg::MODE_W-1:0]  mode,
	input  logic [lmf_pkg::CH_W-1:0]    x_start,
	input  logic [lmf_pkg::CH_W-1:0]    y_start,
	input  logic [lmf_pkg::CH_W-1:0]    x_end,
	input  logic [lmf_pkg::CH_W-1:0]    y_end,
	input  logic [lmf_pkg::CH_W-1:0]    red_in,
	input  logic [lmf_pkg::CH_W-1:0]    green_in,
	input  logic [lmf_pkg::CH_W-1:0]    blue_in,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lmf_pkg::cmd_t               push_cmd
);

	localparam int CW = lmf_pkg::COORD_W;
	localparam int DW = lmf_pkg::CH_W;
	localparam logic [DW-1:0] XMAX = DW'(WIDTH - 1);
	localparam logic [DW-1:0] YMAX = DW'(HEIGHT - 1);

	logic [DW-1:0]           xe_clip;
	logic [DW-1:0]           ye_clip;
	logic [lmf_pkg::RGB_W-1:0] rgb;
	logic                    keep;
	lmf_pkg::cmd_t           cmd;
	logic                    valid_s1;
	lmf_pkg::cmd_t           cmd_s1;

	// Clip the rectangle corner to the matrix
	assign xe_clip = (x_end > XMAX) ? XMAX : x_end;
	assign ye_clip = (y_end > YMAX) ? YMAX : y_end;
	assign rgb     = {red_in, green_in, blue_in};

	// Turn each mode into a rectangle paint or a row scan; flag the ones that do nothing
	always_comb begin
		keep       = 1'b0;
		cmd.op     = lmf_pkg::OP_DRAW;
		cmd.x0     = x_start[CW-1:0];
		cmd.y0     = y_start[CW-1:0];
		cmd.x1     = x_start[CW-1:0];
		cmd.y1     = y_start[CW-1:0];
		cmd.rgb    = rgb;
		unique case (mode) inside
			lmf_pkg::MODE_SET, lmf_pkg::MODE_CLEAR: begin
				keep = (x_start <= XMAX) && (y_start <= YMAX);
				if (mode == lmf_pkg::MODE_CLEAR) begin
					cmd.rgb = '0;
				end
			end
			lmf_pkg::MODE_FILL_ALL, lmf_pkg::MODE_CLEAR_ALL: begin
				keep   = 1'b1;
				cmd.x0 = '0;
				cmd.y0 = '0;
				cmd.x1 = XMAX[CW-1:0];
				cmd.y1 = YMAX[CW-1:0];
				if (mode == lmf_pkg::MODE_CLEAR_ALL) begin
					cmd.rgb = '0;
				end
			end
			lmf_pkg::MODE_RECT: begin
				keep   = (x_start <= xe_clip) && (y_start <= ye_clip);
				cmd.x1 = xe_clip[CW-1:0];
				cmd.y1 = ye_clip[CW-1:0];
			end
			lmf_pkg::MODE_REFRESH: begin
				keep   = (y_start <= YMAX);
				cmd.op = lmf_pkg::OP_REFRESH;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Hold one classified word until the queue takes it
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

>>> hw/rtl/lmf_queue.sv
// Short command queue between the front end and the drawing engine.
module lmf_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_valid,
	output logic                        push_ready,
	input  lmf_pkg::cmd_t               push_cmd,
	output logic                        pop_valid,
	input  logic                        pop_ready,
	output lmf_pkg::cmd_t               pop_cmd,
	output logic [lmf_pkg::QCNT_W-1:0]  count
);

	localparam int PW = lmf_pkg::QPTR_W;
	localparam int NW = lmf_pkg::QCNT_W;

	lmf_pkg::cmd_t   entries_q [lmf_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q < NW'(lmf_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign count      = count_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/lmf_engine.sv
// Back end: paints rectangles into the pixel store and scans rows out in strip order.
module lmf_engine #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  lmf_pkg::cmd_t             cmd,
	output logic                      led_valid,
	input  logic                      led_ready,
	output logic [lmf_pkg::ADDR_W-1:0] led_index,
	output logic [lmf_pkg::CH_W-1:0]  red_out,
	output logic [lmf_pkg::CH_W-1:0]  green_out,
	output logic [lmf_pkg::CH_W-1:0]  blue_out,
	output logic                      row_done,
	output logic                      row_active
);

	localparam int CW    = lmf_pkg::COORD_W;
	localparam int AW    = lmf_pkg::ADDR_W;
	localparam int RW    = lmf_pkg::RGB_W;
	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] WIDTH_A = AW'(WIDTH);
	localparam logic [CW-1:0] XLAST   = CW'(WIDTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DRAW = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]        state_q;
	lmf_pkg::cmd_t     cur_q;
	logic [CW-1:0]     x_q;
	logic [CW-1:0]     y_q;
	logic [CW-1:0]     k_q;

	logic [RW-1:0]     mem [DEPTH];
	logic [DEPTH-1:0]  written_q;

	logic [CW-1:0]     col;
	logic [AW-1:0]     draw_addr;
	logic [AW-1:0]     read_addr;
	logic [AW-1:0]     strip_idx;
	logic              wr_en;
	logic              issue;
	logic              adv_out;
	logic              k_last;

	logic              valid_s1;
	logic [RW-1:0]     rd_data_s1;
	logic              rd_hit_s1;
	logic [AW-1:0]     idx_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [AW-1:0]     idx_q;
	logic [RW-1:0]     rgb_q;
	logic              last_q;

	// Address arithmetic: even rows run right to left on the strip
	assign k_last    = k_q == XLAST;
	assign col       = cur_q.y0[0] ? k_q : XLAST - k_q;
	assign draw_addr = AW'(y_q) * WIDTH_A + AW'(x_q);
	assign read_addr = AW'(cur_q.y0) * WIDTH_A + AW'(col);
	assign strip_idx = AW'(cur_q.y0) * WIDTH_A + AW'(k_q);

	// Output handshake and read issue
	assign adv_out   = !out_valid_q || led_ready;
	assign issue     = (state_q == ST_READ) && (!valid_s1 || adv_out);
	assign wr_en     = state_q == ST_DRAW;
	assign cmd_ready = state_q == ST_IDLE;

	// Sequence the current command one pixel per cycle; a row scan waits while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			y_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						x_q     <= cmd.x0;
						y_q     <= cmd.y0;
						k_q     <= '0;
						state_q <= (cmd.op == lmf_pkg::OP_REFRESH) ? ST_READ : ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (x_q == cur_q.x1) begin
						x_q <= cur_q.x0;
						if (y_q == cur_q.y1) begin
							state_q <= ST_IDLE;
						end else begin
							y_q <= y_q + CW'(1);
						end
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
				ST_READ: begin
					if (issue) begin
						k_q <= k_q + CW'(1);
						if (k_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the command being worked on
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
	end

	// Mark entries written since reset; unwritten entries read as black
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[draw_addr[DAW-1:0]] <= 1'b1;
		end
	end

	// Pixel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[draw_addr[DAW-1:0]] <= cur_q.rgb;
		end
		if (issue) begin
			rd_data_s1 <= mem[read_addr[DAW-1:0]];
			rd_hit_s1  <= written_q[read_addr[DAW-1:0]];
			idx_s1     <= strip_idx;
			last_s1    <= k_last;
		end
	end

	// Read stage and output register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Move the read word into the output register
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			idx_q  <= idx_s1;
			rgb_q  <= rd_hit_s1 ? rd_data_s1 : '0;
			last_q <= last_s1;
		end
	end

	assign led_valid  = out_valid_q;
	assign led_index  = idx_q;
	assign red_out    = rgb_q[RW-1 -: lmf_pkg::CH_W];
	assign green_out  = rgb_q[2*lmf_pkg::CH_W-1 -: lmf_pkg::CH_W];
	assign blue_out   = rgb_q[lmf_pkg::CH_W-1:0];
	assign row_done   = last_q;
	assign row_active = (state_q == ST_READ) || valid_s1;

endmodule

>>> hw/rtl/led_matrix_framebuffer.sv
// Top level of the LED matrix frame buffer: front end, command queue, drawing engine.
//
// Usage:
//   Command words enter on cmd_valid/cmd_ready with mode, x_start, y_start, x_end, y_end
//   and the color (red_in, green_in, blue_in). Set, clear, fill all, clear all and fill
//   rectangle update the WIDTH x HEIGHT pixel store and give no output. A refresh word
//   gives WIDTH LED words on led_valid/led_ready, in strip order (even rows reversed),
//   with row_done on the last one. Off-matrix pixels, empty rectangles, missing rows and
//   unused modes are dropped in the front end.
// Timing:
//   A paint command is loaded into the engine, which then writes each pixel of its clipped
//   rectangle. A refresh reads one pixel per cycle from the single store read port while
//   the output is not stalled; each LED word is registered in the read stage and again
//   in the output register.
//   Up to four classified commands wait in the queue, so new words are taken while the
//   engine is busy or a result waits.
// Reset and stall:
//   Reset clears control state and per-pixel written flags, so the store reads black at
//   once with no clearing pass. When the receiver holds led_ready low, the row scan stops
//   and the held word stays on the outputs; the front end keeps filling the queue.
module led_matrix_framebuffer #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [lmf_pkg::MODE_W-1:0]   mode,
	input  logic [lmf_pkg::CH_W-1:0]     x_start,
	input  logic [lmf_pkg::CH_W-1:0]     y_start,
	input  logic [lmf_pkg::CH_W-1:0]     x_end,
	input  logic [lmf_pkg::CH_W-1:0]     y_end,
	input  logic [lmf_pkg::CH_W-1:0]     red_in,
	input  logic [lmf_pkg::CH_W-1:0]     green_in,
	input  logic [lmf_pkg::CH_W-1:0]     blue_in,
	output logic                         led_valid,
	input  logic                         led_ready,
	output logic [lmf_pkg::ADDR_W-1:0]   led_index,
	output logic [lmf_pkg::CH_W-1:0]     red_out,
	output logic [lmf_pkg::CH_W-1:0]     green_out,
	output logic [lmf_pkg::CH_W-1:0]     blue_out,
	output logic                         row_done
);

	logic                         push_valid;
	logic                         push_ready;
	lmf_pkg::cmd_t                push_cmd;
	logic                         q_valid;
	logic                         q_ready;
	lmf_pkg::cmd_t                q_cmd;
	logic [lmf_pkg::QCNT_W-1:0]   q_count;
	logic                         row_active;

	// Classify incoming words
	lmf_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_valid),
		.in_ready   (cmd_ready),
		.mode       (mode),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Buffer classified commands
	lmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd),
		.count      (q_count)
	);

	// Paint and scan out
	lmf_engine #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd        (q_cmd),
		.led_valid  (led_valid),
		.led_ready  (led_ready),
		.led_index  (led_index),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.row_done   (row_done),
		.row_active (row_active)
	);

`ifndef NO_ASSERTIONS
	// A row never stops short: after a word that is not the last, more of the row follows
	a_row_continues: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && led_ready && !row_done |=> led_valid || row_active)
		else $error("row scan ended before its last LED word");

	// The queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= lmf_pkg::QCNT_W'(lmf_pkg::QDEPTH))
		else $error("command queue overflow");

	// The engine takes a command only when the queue has one
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready && q_valid |-> q_count != '0)
		else $error("command popped from an empty queue");
`endif

endmodule

>>> bench/led_frame_checker.sv
// Watches the command and LED channels, predicts each LED word and compares it.
module led_frame_checker #(
	parameter int WIDTH  = 16,
	parameter int HEIGHT = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  logic [lmf_pkg::MODE_W-1:0]   mode,
	input  logic [lmf_pkg::CH_W-1:0]     x_start,
	input  logic [lmf_pkg::CH_W-1:0]     y_start,
	input  logic [lmf_pkg::CH_W-1:0]     x_end,
	input  logic [lmf_pkg::CH_W-1:0]     y_end,
	input  logic [lmf_pkg::CH_W-1:0]     red_in,
	input  logic [lmf_pkg::CH_W-1:0]     green_in,
	input  logic [lmf_pkg::CH_W-1:0]     blue_in,
	input  logic                         led_valid,
	input  logic                         led_ready,
	input  logic [lmf_pkg::ADDR_W-1:0]   led_index,
	input  logic [lmf_pkg::CH_W-1:0]     red_out,
	input  logic [lmf_pkg::CH_W-1:0]     green_out,
	input  logic [lmf_pkg::CH_W-1:0]     blue_out,
	input  logic                         row_done,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW    = lmf_pkg::ADDR_W;
	localparam int DW    = lmf_pkg::CH_W;
	localparam int MW    = lmf_pkg::MODE_W;
	localparam int RW    = lmf_pkg::RGB_W;
	localparam int CELLS = 1 << AW;

	typedef struct packed {
		logic [AW-1:0] index;
		logic [DW-1:0] red;
		logic [DW-1:0] green;
		logic [DW-1:0] blue;
		logic          last;
	} led_word_t;

	logic [RW-1:0] pix_mem [CELLS];
	led_word_t     led_words_due [$];
	led_word_t     due;
	int            errors;

	assign fail_count = errors;

	// Print one line per mismatch and count it
	task automatic flag(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [AW-1:0] cell_of(input int x, input int y);
		return AW'(y * WIDTH + x);
	endfunction

	// Paint a rectangle clipped to the matrix; an inverted one paints nothing
	task automatic paint_area(input int x0, input int y0, input int x1, input int y1,
			input logic [RW-1:0] rgb);
		int xl, yl;
		xl = (x1 > WIDTH - 1) ? WIDTH - 1 : x1;
		yl = (y1 > HEIGHT - 1) ? HEIGHT - 1 : y1;
		if (x0 <= xl && y0 <= yl) begin
			for (int y = y0; y <= yl; y++) begin
				for (int x = x0; x <= xl; x++) begin
					pix_mem[cell_of(x, y)] = rgb;
				end
			end
		end
	endtask

	// Apply one command word to the frame copy and queue the LED words it yields
	task automatic draw_command(input logic [MW-1:0] m, input logic [DW-1:0] xs,
			input logic [DW-1:0] ys, input logic [DW-1:0] xe,
			input logic [DW-1:0] ye, input logic [RW-1:0] rgb);
		led_word_t w;
		int col;
		case (m)
			lmf_pkg::MODE_SET, lmf_pkg::MODE_CLEAR: begin
				if (xs < WIDTH && ys < HEIGHT) begin
					pix_mem[cell_of(xs, ys)] = (m == lmf_pkg::MODE_SET) ? rgb : '0;
				end
			end
			lmf_pkg::MODE_FILL_ALL:  paint_area(0, 0, WIDTH - 1, HEIGHT - 1, rgb);
			lmf_pkg::MODE_CLEAR_ALL: paint_area(0, 0, WIDTH - 1, HEIGHT - 1, '0);
			lmf_pkg::MODE_RECT:      paint_area(xs, ys, xe, ye, rgb);
			lmf_pkg::MODE_REFRESH: begin
				if (ys < HEIGHT) begin
					for (int k = 0; k < WIDTH; k++) begin
						// even rows run right to left along the strip
						col = ys[0] ? k : WIDTH - 1 - k;
						{w.red, w.green, w.blue} = pix_mem[cell_of(col, ys)];
						w.index = AW'(ys * WIDTH + k);
						w.last  = (k == WIDTH - 1);
						led_words_due.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Check LED words first, then take the command accepted on this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				pix_mem[i] = '0;
			end
			led_words_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (led_valid && led_ready) begin
				if (led_words_due.size() == 0) begin
					flag($sformatf("LED word at index %0d with none due", led_index));
				end else begin
					due = led_words_due.pop_front();
					if (led_index !== due.index) begin
						flag($sformatf("led_index %0d, want %0d", led_index, due.index));
					end
					if (red_out !== due.red) begin
						flag($sformatf("red_out %0h at %0d, want %0h", red_out, due.index,
							due.red));
					end
					if (green_out !== due.green) begin
						flag($sformatf("green_out %0h at %0d, want %0h", green_out, due.index,
							due.green));
					end
					if (blue_out !== due.blue) begin
						flag($sformatf("blue_out %0h at %0d, want %0h", blue_out, due.index,
							due.blue));
					end
					if (row_done !== due.last) begin
						flag($sformatf("row_done %b at %0d, want %b", row_done, due.index,
							due.last));
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				draw_command(mode, x_start, y_start, x_end, y_end,
					{red_in, green_in, blue_in});
			end
			pending <= led_words_due.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// Top of the frame buffer bench: clock, reset, command and LED stimulus, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH         = 16;
	localparam int HEIGHT        = 16;
	localparam int HALF_PERIOD   = 1;
	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 1400;
	localparam int RANDOM_WORDS  = 134;
	localparam int LIMIT_NS      = 1_500_000;
	localparam int MW            = lmf_pkg::MODE_W;
	localparam int CW            = lmf_pkg::CH_W;
	localparam int AW            = lmf_pkg::ADDR_W;

	// Modes the block leaves unused
	localparam logic [MW-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MW-1:0] MODE_SPARE_B = 3'd7;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_ready;
	logic [MW-1:0] mode;
	logic [CW-1:0] x_start;
	logic [CW-1:0] y_start;
	logic [CW-1:0] x_end;
	logic [CW-1:0] y_end;
	logic [CW-1:0] red_in;
	logic [CW-1:0] green_in;
	logic [CW-1:0] blue_in;
	logic          led_valid;
	logic          led_ready;
	logic [AW-1:0] led_index;
	logic [CW-1:0] red_out;
	logic [CW-1:0] green_out;
	logic [CW-1:0] blue_out;
	logic          row_done;
	int            fail_count;
	int            pending;
	bit            calm;
	bit            hold_req;

	always #(HALF_PERIOD) clk = ~clk;

	led_matrix_framebuffer #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .mode(mode),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.led_valid(led_valid), .led_ready(led_ready), .led_index(led_index),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.row_done(row_done)
	);

	led_frame_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .mode(mode),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.led_valid(led_valid), .led_ready(led_ready), .led_index(led_index),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.row_done(row_done), .fail_count(fail_count), .pending(pending)
	);

	// Offer one command word after a random gap (none while calm), hold it until accepted
	task automatic send_word(input logic [MW-1:0] m, input logic [CW-1:0] xs,
			input logic [CW-1:0] ys, input logic [CW-1:0] xe,
			input logic [CW-1:0] ye, input logic [CW-1:0] r,
			input logic [CW-1:0] g, input logic [CW-1:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		mode      <= m;
		x_start   <= xs;
		y_start   <= ys;
		x_end     <= xe;
		y_end     <= ye;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	// Drop valid and wait until every due LED word has come back
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Pick a mostly well-formed command with random content, some noise
	task automatic random_word();
		logic [MW-1:0] m;
		logic [CW-1:0] xs, ys, xe, ye;
		int pick;
		pick = $urandom_range(99);
		xs = CW'($urandom_range(WIDTH - 1));
		ys = CW'($urandom_range(HEIGHT - 1));
		xe = CW'($urandom);
		ye = CW'($urandom);
		if (pick < 30) begin
			m = lmf_pkg::MODE_REFRESH;
			if ($urandom_range(9) == 0) ys = CW'($urandom);
		end else if (pick < 55) begin
			m = lmf_pkg::MODE_SET;
			if ($urandom_range(9) == 0) xs = CW'($urandom);
			if ($urandom_range(9) == 0) ys = CW'($urandom);
		end else if (pick < 65) begin
			m = lmf_pkg::MODE_CLEAR;
			if ($urandom_range(9) == 0) ys = CW'($urandom);
		end else if (pick < 80) begin
			m = lmf_pkg::MODE_RECT;
			if ($urandom_range(4) == 0) begin
				xs = CW'($urandom);
				ys = CW'($urandom);
			end else begin
				xe = CW'(xs + $urandom_range(5));
				ye = CW'(ys + $urandom_range(5));
			end
		end else if (pick < 86) begin
			m = lmf_pkg::MODE_FILL_ALL;
		end else if (pick < 90) begin
			m = lmf_pkg::MODE_CLEAR_ALL;
		end else if (pick < 95) begin
			m = MW'($urandom);
			xs = CW'($urandom);
			ys = CW'($urandom);
		end else begin
			m = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
		end
		send_word(m, xs, ys, xe, ye, CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	// Drain LED words: random stalls, one long hold when the sender asks
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 0;
		led_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				led_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				led_ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1;
				hold_left  = HOLD_CYCLES - 1;
				led_ready <= 1'b0;
			end else begin
				led_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Reset, directed words, random words, drain and verdict
	initial begin
		calm      = 0;
		hold_req  = 0;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		mode      <= lmf_pkg::MODE_SET;
		x_start   <= '0;
		y_start   <= '0;
		x_end     <= '0;
		y_end     <= '0;
		red_in    <= '0;
		green_in  <= '0;
		blue_in   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black store right after reset, both strip directions
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_REFRESH, 8'hff, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		// corner pixels, unused fields carry junk
		send_word(lmf_pkg::MODE_SET, 8'd0, 8'd0, 8'hff, 8'h80, 8'hff, 8'hff, 8'hff);
		send_word(lmf_pkg::MODE_SET, 8'd15, 8'd0, 8'h00, 8'h7f, 8'h01, 8'h80, 8'h7f);
		send_word(lmf_pkg::MODE_SET, 8'd15, 8'd15, 8'h5a, 8'ha5, 8'haa, 8'h55, 8'h00);
		send_word(lmf_pkg::MODE_SET, 8'd0, 8'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff);
		// pixels off the matrix are dropped
		send_word(lmf_pkg::MODE_SET, 8'd16, 8'd0, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56);
		send_word(lmf_pkg::MODE_SET, 8'hff, 8'hff, 8'h00, 8'h00, 8'h9a, 8'hbc, 8'hde);
		send_word(lmf_pkg::MODE_CLEAR, 8'd0, 8'd16, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_CLEAR, 8'd15, 8'd0, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// rectangle inside, then one clipped at both far edges
		send_word(lmf_pkg::MODE_RECT, 8'd4, 8'd2, 8'd9, 8'd3, 8'h33, 8'hcc, 8'h0f);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_RECT, 8'd12, 8'd14, 8'hff, 8'hff, 8'hf0, 8'h0f, 8'h3c);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// empty rectangles
		send_word(lmf_pkg::MODE_RECT, 8'd9, 8'd0, 8'd8, 8'd15, 8'hff, 8'hff, 8'hff);
		send_word(lmf_pkg::MODE_RECT, 8'hff, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		// rows that do not exist, unused modes
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd16, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(MODE_SPARE_A, 8'd1, 8'd1, 8'd5, 8'd5, 8'hff, 8'hff, 8'hff);
		send_word(MODE_SPARE_B, 8'd2, 8'd2, 8'd6, 8'd6, 8'hff, 8'hff, 8'hff);
		// whole-store fill and clear
		send_word(lmf_pkg::MODE_FILL_ALL, 8'hff, 8'hff, 8'h00, 8'h00, 8'h81, 8'h42, 8'h24);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(lmf_pkg::MODE_CLEAR_ALL, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		send_word(lmf_pkg::MODE_REFRESH, 8'h00, 8'd15, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// pause for a full drain now and then
			if (i == 56 || i == 130) wait_drained();
			calm = (i >= 70 && i < 110);
			if (i >= 40 && i < 52) begin
				// long LED hold while refreshes keep coming: fill the queue
				hold_req = 1;
				send_word(lmf_pkg::MODE_REFRESH, CW'($urandom),
					CW'($urandom_range(HEIGHT - 1)), CW'($urandom), CW'($urandom),
					CW'($urandom), CW'($urandom), CW'($urandom));
			end else begin
				random_word();
			end
		end
		calm = 0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// End a hung run
	initial begin
		#(LIMIT_NS);
		$display("tb_top failed");
		$finish;
	end

endmodule
